// File: src/key_release_gate_macros.svh
// key_release_gate_macros.svh: assertion macros shared by the gate modules
// depends on clk and rst_n being visible in the module that uses them
`ifndef KEY_RELEASE_GATE_MACROS_SVH
`define KEY_RELEASE_GATE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define KRG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define KRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/krg_pkg.sv
// krg_pkg: constants, codes and controller/datapath interface types
// for the key release gate; no dependencies
package krg_pkg;

  localparam int KEY_W      = 16;
  localparam int HELD_DEPTH = 8;
  localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [KEY_W-1:0] KC_NO   = KEY_W'(0);
  localparam logic [KEY_W-1:0] KC_A    = KEY_W'(4);
  localparam logic [KEY_W-1:0] KC_RGUI = KEY_W'(231);

  // gate modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WATCH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEND    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GATED_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GATED_HIGH = 1'b1;

  // result kinds
  localparam logic KIND_DECISION = 1'b0;
  localparam logic KIND_FORCED   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;   // request taken this cycle
    logic forced;   // emit one stored key as a forced release
    logic final_dec; // emit the held decision and clear the store
  } krg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic flush_go;  // the offered request releases the lever with keys stored
    logic idx_last;  // flush pointer is on the newest stored key
  } krg_stat_t;

endpackage

// File: src/key_release_gate.sv
// key_release_gate: top level of the keyboard release gate
// depends on krg_pkg, krg_ctrl and krg_datapath
//
// Usage:
//   A request (in_operation, in_pressed, in_key_code) is taken at a rising
//   edge with start high and busy low. Every request yields one decision
//   result (out_kind 0, out_last 1). A lever release in suspend first yields
//   one forced release (out_kind 1) per stored key, oldest first.
//   Each result is shown for one cycle with out_valid high; the receiver
//   cannot stall, so results are never held.
//   With no flush the decision is registered and shows in the cycle after the
//   request is taken; a flush passes the flush state before its first forced
//   release is registered. With no flush busy stays low and the next request
//   may follow at once. A flush of N stored keys (1 to 8) produces N+1 results
//   in consecutive cycles, one per cycle, limited by the single read port of
//   the key store; busy stays high through the flush and final states. cfg_we
//   writes cfg_data into register cfg_index (0 gated_low, 1 gated_high) in
//   the same edge; the user writes only while idle, the block does not check.
//   Reset (rst_n low, synchronous): mode idle, no lever, store empty, range
//   back to 4..231, no result pending. The store needs no clearing pass.
module key_release_gate (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic                            in_pressed,
  input  logic [krg_pkg::KEY_W-1:0]       in_key_code,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic                            out_forward,
  output logic [krg_pkg::KEY_W-1:0]       out_code,
  output logic                            out_dropped,
  output logic                            out_last,
  input  logic                            cfg_we,
  input  logic [krg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krg_pkg::KEY_W-1:0]       cfg_data
);
  import krg_pkg::*;

  krg_cmd_t  cmd;
  krg_stat_t stat;

  // sequencer
  krg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // state, store and results
  krg_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_operation),
    .in_pressed   (in_pressed),
    .in_key_code  (in_key_code),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_forward  (out_forward),
    .out_code     (out_code),
    .out_dropped  (out_dropped),
    .out_last     (out_last)
  );

endmodule

// File: src/krg_ctrl.sv
// krg_ctrl: sequencer for the key release gate, sets the flush order
// depends on krg_pkg and key_release_gate_macros.svh
module krg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  krg_pkg::krg_stat_t stat,
  output krg_pkg::krg_cmd_t  cmd
);
  import krg_pkg::*;
  `include "key_release_gate_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // commands
  assign cmd.accept    = accept;
  assign cmd.forced    = (state_r == S_FLUSH);
  assign cmd.final_dec = (state_r == S_FINAL);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && stat.flush_go) state_nxt = S_FLUSH;
      S_FLUSH: if (stat.idx_last) state_nxt = S_FINAL;
      S_FINAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `KRG_ASSERT_NEXT(a_flush_entry, accept && stat.flush_go, state_r == S_FLUSH, "flush not entered")
  `KRG_ASSERT_NEXT(a_final_once, state_r == S_FINAL, state_r == S_IDLE, "final not followed by idle")
  `KRG_ASSERT_NOW(a_idle_state, state_r != S_FLUSH && state_r != S_FINAL, state_r == S_IDLE, "bad state")

endmodule

// File: src/krg_datapath.sv
// krg_datapath: gate mode, lever, key store, range registers and result registers
// depends on krg_pkg and key_release_gate_macros.svh
module krg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  krg_pkg::krg_cmd_t               cmd,
  output krg_pkg::krg_stat_t              stat,
  input  logic                            in_operation,
  input  logic                            in_pressed,
  input  logic [krg_pkg::KEY_W-1:0]       in_key_code,
  input  logic                            cfg_we,
  input  logic [krg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krg_pkg::KEY_W-1:0]       cfg_data,
  output logic                            out_valid,
  output logic                            out_kind,
  output logic                            out_forward,
  output logic [krg_pkg::KEY_W-1:0]       out_code,
  output logic                            out_dropped,
  output logic                            out_last
);
  import krg_pkg::*;
  `include "key_release_gate_macros.svh"

  logic [KEY_W-1:0]  low_r, high_r;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [KEY_W-1:0]  lever_r, lever_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  idx_r;
  logic [KEY_W-1:0]  held_mem [HELD_DEPTH];

  logic              dec_code_unused;
  logic [KEY_W-1:0]  dec_code_r;

  logic              out_valid_r, out_kind_r, out_forward_r, out_dropped_r, out_last_r;
  logic [KEY_W-1:0]  out_code_r;

  logic gated, full, fwd, drop, store, flush;

  assign dec_code_unused = 1'b0;
  assign full  = (count_r == CNT_W'(HELD_DEPTH));
  assign gated = (in_key_code >= low_r) && (in_key_code <= high_r);

  // decision on the offered request
  always_comb begin
    mode_nxt  = mode_r;
    lever_nxt = lever_r;
    fwd       = 1'b1;
    drop      = 1'b0;
    store     = 1'b0;
    flush     = 1'b0;
    if (in_operation) begin
      mode_nxt = in_pressed ? MODE_BLOCK : ((lever_r == KC_NO) ? MODE_WATCH : MODE_LEND);
      fwd      = 1'b0;
    end else if (mode_r != MODE_IDLE && gated) begin
      if (in_pressed) begin
        if (mode_r == MODE_BLOCK) begin
          lever_nxt = in_key_code;
        end else if (mode_r == MODE_WATCH) begin
          lever_nxt = in_key_code;
          mode_nxt  = MODE_SUSPEND;
        end
      end else if (mode_r == MODE_BLOCK || mode_r == MODE_LEND) begin
        store = 1'b1;
        drop  = full;
        fwd   = 1'b0;
        if (lever_r == in_key_code) begin
          lever_nxt = KC_NO;
          if (mode_r == MODE_LEND) mode_nxt = MODE_WATCH;
        end
      end else if (mode_r == MODE_SUSPEND && lever_r == in_key_code) begin
        lever_nxt = KC_NO;
        mode_nxt  = MODE_IDLE;
        flush     = 1'b1;
      end
    end
  end

  // status
  assign stat.flush_go = flush && (count_r != CNT_W'(0));
  assign stat.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= KC_A;
      high_r <= KC_RGUI;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GATED_LOW:  low_r  <= cfg_data;
        REG_GATED_HIGH: high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // gate state, store fill count and flush pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      lever_r <= KC_NO;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.accept) begin
        mode_r  <= mode_nxt;
        lever_r <= lever_nxt;
        idx_r   <= '0;
        if (store && !full) count_r <= count_r + CNT_W'(1);
      end
      if (cmd.forced) idx_r <= idx_r + IDX_W'(1);
      if (cmd.final_dec) count_r <= '0;
    end
  end

  // key store
  always_ff @(posedge clk) begin
    if (cmd.accept && store && !full) held_mem[count_r[IDX_W-1:0]] <= in_key_code;
  end

  // decision kept for the end of a flush (always forwarded, never dropped)
  always_ff @(posedge clk) begin
    if (cmd.accept) dec_code_r <= in_key_code;
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.accept && !stat.flush_go) || cmd.forced || cmd.final_dec;
    end
  end

  // result payload, store read is registered here
  always_ff @(posedge clk) begin
    if (cmd.forced) begin
      out_kind_r    <= KIND_FORCED;
      out_forward_r <= 1'b0;
      out_code_r    <= held_mem[idx_r];
      out_dropped_r <= 1'b0;
      out_last_r    <= 1'b0;
    end else if (cmd.final_dec) begin
      out_kind_r    <= KIND_DECISION;
      out_forward_r <= 1'b1;
      out_code_r    <= dec_code_r;
      out_dropped_r <= dec_code_unused;
      out_last_r    <= 1'b1;
    end else if (cmd.accept) begin
      out_kind_r    <= KIND_DECISION;
      out_forward_r <= fwd;
      out_code_r    <= in_key_code;
      out_dropped_r <= drop;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_forward = out_forward_r;
  assign out_code    = out_code_r;
  assign out_dropped = out_dropped_r;
  assign out_last    = out_last_r;

  `KRG_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(HELD_DEPTH), "store count overflow")
  `KRG_ASSERT_NEXT(a_forced_out, cmd.forced, out_valid_r && out_kind_r == KIND_FORCED && !out_last_r, "forced release missing")
  `KRG_ASSERT_NEXT(a_final_out, cmd.final_dec, out_valid_r && out_last_r && count_r == CNT_W'(0), "flush did not end cleanly")

endmodule

// File: sim/key_release_gate_test.sv
// key_release_gate_test: self-checking bench for the keyboard release gate
// drives requests and range writes, predicts every result in a tracker class
// depends on krg_pkg and key_release_gate
module key_release_gate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import krg_pkg::*;

  localparam logic OP_KEY      = 1'b0;
  localparam logic OP_GATE     = 1'b1;
  localparam logic KEY_RELEASE = 1'b0;
  localparam logic KEY_PRESS   = 1'b1;
  localparam int   STALL_LIMIT = 1000;
  localparam int   PHASE_ITEMS = 16;

  typedef struct packed {
    logic             kind;
    logic             forward;
    logic [KEY_W-1:0] code;
    logic             dropped;
    logic             last;
  } gate_result_t;

  // tracks gate mode, lever and stored releases, queues expected results
  class key_gate_tracker;
    logic [KEY_W-1:0]  range_lo;
    logic [KEY_W-1:0]  range_hi;
    logic [MODE_W-1:0] gate_state;
    logic [KEY_W-1:0]  lever;
    logic [KEY_W-1:0]  stash [HELD_DEPTH];
    int                stash_count;
    gate_result_t      pending_results[$];
    int                errors;
    int                requests;
    int                results_seen;
    int                flushes;
    int                drops;

    function new();
      range_lo    = KC_A;
      range_hi    = KC_RGUI;
      gate_state  = MODE_IDLE;
      lever       = KC_NO;
      stash_count = 0;
      errors      = 0;
      requests    = 0;
      results_seen = 0;
      flushes     = 0;
      drops       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
      if (idx == REG_GATED_LOW) range_lo = data;
      else range_hi = data;
    endfunction

    function void add_result(logic kind, logic fwd, logic [KEY_W-1:0] code,
                             logic drop, logic fin);
      gate_result_t r;
      r.kind    = kind;
      r.forward = fwd;
      r.code    = code;
      r.dropped = drop;
      r.last    = fin;
      pending_results.push_back(r);
    endfunction

    // one accepted request: update state, queue forced releases and the decision
    function void note_request(logic op, logic prs, logic [KEY_W-1:0] code);
      logic fwd;
      logic drop;
      logic gated;
      fwd   = 1'b1;
      drop  = 1'b0;
      gated = (code >= range_lo) && (code <= range_hi);
      requests++;
      if (op == OP_GATE) begin
        if (prs == KEY_PRESS) gate_state = MODE_BLOCK;
        else gate_state = (lever == KC_NO) ? MODE_WATCH : MODE_LEND;
        fwd = 1'b0;
      end else if (gate_state != MODE_IDLE && gated) begin
        if (prs == KEY_PRESS) begin
          if (gate_state == MODE_BLOCK) begin
            lever = code;
          end else if (gate_state == MODE_WATCH) begin
            lever      = code;
            gate_state = MODE_SUSPEND;
          end
        end else if (gate_state == MODE_BLOCK || gate_state == MODE_LEND) begin
          // held release: store it, or flag it when the store is full
          if (stash_count < HELD_DEPTH) begin
            stash[stash_count] = code;
            stash_count++;
          end else begin
            drop = 1'b1;
            drops++;
          end
          if (lever == code) begin
            lever = KC_NO;
            if (gate_state == MODE_LEND) gate_state = MODE_WATCH;
          end
          fwd = 1'b0;
        end else if (gate_state == MODE_SUSPEND && lever == code) begin
          // lever released: flush stored keys oldest first
          lever      = KC_NO;
          gate_state = MODE_IDLE;
          for (int i = 0; i < stash_count; i++)
            add_result(KIND_FORCED, 1'b0, stash[i], 1'b0, 1'b0);
          if (stash_count > 0) flushes++;
          stash_count = 0;
        end
      end
      add_result(KIND_DECISION, fwd, code, drop, 1'b1);
    endfunction

    function void check_result(gate_result_t got);
      gate_result_t exp;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d code %0d", got.kind, got.code);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got.kind !== exp.kind) begin
        $error("out_kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.forward !== exp.forward) begin
        $error("out_forward: expected %0d, got %0d", exp.forward, got.forward);
        errors++;
      end
      if (got.code !== exp.code) begin
        $error("out_code: expected %0d, got %0d", exp.code, got.code);
        errors++;
      end
      if (got.dropped !== exp.dropped) begin
        $error("out_dropped: expected %0d, got %0d", exp.dropped, got.dropped);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("out_last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_operation = OP_KEY;
  logic                 in_pressed = KEY_RELEASE;
  logic [KEY_W-1:0]     in_key_code = KC_NO;
  logic                 out_valid;
  logic                 out_kind;
  logic                 out_forward;
  logic [KEY_W-1:0]     out_code;
  logic                 out_dropped;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GATED_LOW;
  logic [KEY_W-1:0]     cfg_data = KC_NO;

  key_gate_tracker tracker;
  int              burst_left = 0;
  int              quiet_cycles = 0;
  int              range_settings = 1;

  key_release_gate u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_pressed   (in_pressed),
    .in_key_code  (in_key_code),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_forward  (out_forward),
    .out_code     (out_code),
    .out_dropped  (out_dropped),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    gate_result_t got;
    if (rst_n && out_valid) begin
      got.kind    = out_kind;
      got.forward = out_forward;
      got.code    = out_code;
      got.dropped = out_dropped;
      got.last    = out_last;
      tracker.check_result(got);
    end
  end

  // watchdog on cycles with no request taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // send one request, with bursts and random gaps between them
  task automatic send_request(input logic op, input logic prs, input logic [KEY_W-1:0] code);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
    end
    burst_left--;
    start        <= 1'b1;
    in_operation <= op;
    in_pressed   <= prs;
    in_key_code  <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(op, prs, code);
  endtask

  // hold requests off until every expected result is back
  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GATED_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    tracker.set_reg(REG_GATED_LOW, lo);
    cfg_index <= REG_GATED_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    tracker.set_reg(REG_GATED_HIGH, hi);
    cfg_we <= 1'b0;
    range_settings++;
  endtask

  // a few codes at the bottom of the gated range, so levers get matched
  function automatic logic [KEY_W-1:0] gated_code();
    int span;
    span = int'(tracker.range_hi) - int'(tracker.range_lo);
    if (span < 0) return KEY_W'($urandom);
    if (span > 5) span = 5;
    return tracker.range_lo + KEY_W'($urandom_range(0, span));
  endfunction

  function automatic logic [KEY_W-1:0] any_code();
    if ($urandom_range(0, 7) == 0) return KEY_W'($urandom);
    return gated_code();
  endfunction

  // well-formed gate session: block, optional lend, watch, suspend, flush
  task automatic gate_session();
    logic [KEY_W-1:0] code;
    int               n;
    send_request(OP_GATE, KEY_PRESS, KEY_W'($urandom));
    n = $urandom_range(0, 10);
    repeat (n) begin
      code = any_code();
      if ($urandom_range(0, 4) == 0) send_request(OP_KEY, KEY_PRESS, code);
      else send_request(OP_KEY, KEY_RELEASE, code);
    end
    if (tracker.lever != KC_NO && $urandom_range(0, 1) == 1)
      send_request(OP_KEY, KEY_RELEASE, tracker.lever);
    send_request(OP_GATE, KEY_RELEASE, KEY_W'($urandom));
    if (tracker.gate_state == MODE_LEND) begin
      repeat ($urandom_range(0, 2)) send_request(OP_KEY, KEY_RELEASE, any_code());
      send_request(OP_KEY, KEY_RELEASE, tracker.lever);
    end
    if (tracker.gate_state == MODE_WATCH)
      send_request(OP_KEY, KEY_PRESS, gated_code());
    repeat ($urandom_range(0, 2)) begin
      code = any_code();
      send_request(OP_KEY, $urandom_range(0, 1) == 1 ? KEY_PRESS : KEY_RELEASE, code);
    end
    if (tracker.gate_state == MODE_SUSPEND)
      send_request(OP_KEY, KEY_RELEASE, tracker.lever);
  endtask

  task automatic noise_request();
    logic op;
    op = ($urandom_range(0, 7) == 0) ? OP_GATE : OP_KEY;
    send_request(op, $urandom_range(0, 1) == 1 ? KEY_PRESS : KEY_RELEASE, any_code());
  endtask

  task automatic random_phase(input int items);
    int target;
    target = tracker.requests + items;
    while (tracker.requests < target) begin
      if ($urandom_range(0, 9) < 7) gate_session();
      else noise_request();
    end
  endtask

  initial begin
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle: everything passes, extremes of the code field
    send_request(OP_KEY, KEY_PRESS, KC_A);
    send_request(OP_KEY, KEY_RELEASE, KC_NO);
    send_request(OP_KEY, KEY_RELEASE, 16'hFFFF);
    // block with a lever, stored and ungated releases, then lend
    send_request(OP_GATE, KEY_PRESS, 16'hFFFF);
    send_request(OP_KEY, KEY_PRESS, 16'd10);
    send_request(OP_KEY, KEY_RELEASE, 16'd11);
    send_request(OP_KEY, KEY_RELEASE, 16'd3);
    send_request(OP_GATE, KEY_RELEASE, KC_NO);
    send_request(OP_KEY, KEY_PRESS, 16'd12);
    send_request(OP_KEY, KEY_RELEASE, 16'd13);
    send_request(OP_KEY, KEY_RELEASE, 16'd10);
    // watch, suspend, non-lever traffic, then the flush
    send_request(OP_KEY, KEY_RELEASE, 16'd14);
    send_request(OP_KEY, KEY_PRESS, 16'd20);
    send_request(OP_KEY, KEY_PRESS, 16'd21);
    send_request(OP_KEY, KEY_RELEASE, 16'd21);
    send_request(OP_KEY, KEY_RELEASE, 16'd20);
    // full store: the ninth held release is dropped, then a full flush
    send_request(OP_GATE, KEY_PRESS, KC_NO);
    for (int i = 0; i < HELD_DEPTH; i++)
      send_request(OP_KEY, KEY_RELEASE, KC_A + KEY_W'(i));
    send_request(OP_KEY, KEY_RELEASE, KC_RGUI);
    send_request(OP_GATE, KEY_RELEASE, KC_NO);
    send_request(OP_KEY, KEY_PRESS, KC_RGUI);
    send_request(OP_KEY, KEY_RELEASE, KC_RGUI);

    // random traffic over several gated ranges
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_range(16'h0000, 16'hFFFF);
    random_phase(PHASE_ITEMS / 2);
    wait_drained();
    random_phase(PHASE_ITEMS / 2);
    wait_drained();
    write_range(16'hFFF0, 16'hFFFF);
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_range(16'd300, 16'd200);
    random_phase(PHASE_ITEMS / 2);
    wait_drained();
    write_range(16'h0000, 16'h0000);
    random_phase(PHASE_ITEMS);
    wait_drained();
    write_range(16'hFFFF, 16'hFFFF);
    random_phase(PHASE_ITEMS / 2);
    wait_drained();
    write_range(KC_A, KC_RGUI);
    random_phase(PHASE_ITEMS);
    wait_drained();
    repeat (12) @(posedge clk);

    $display("run covered %0d requests and %0d results over %0d gated ranges",
             tracker.requests, tracker.results_seen, range_settings);
    $display("store flushes: %0d, dropped releases: %0d", tracker.flushes, tracker.drops);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/krg_pkg.sv
src/krg_ctrl.sv
src/krg_datapath.sv
src/key_release_gate.sv
sim/key_release_gate_test.sv
